FILE: rtl/mips_main_control_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef MIPS_MAIN_CONTROL_DECODER_ASSERT_SVH
`define MIPS_MAIN_CONTROL_DECODER_ASSERT_SVH

// Property checked on every rising edge, suspended while reset is asserted.
`define MMCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define MMCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/mmcd_pkg.sv
// Shared types and encodings for the MIPS main control decoder.
// No dependencies; used by the interfaces, the decode logic and the top level.
package mmcd_pkg;

    localparam int OPC_W   = 6;
    localparam int FUNCT_W = 6;

    // Primary opcodes.
    localparam logic [OPC_W-1:0] OP_RTYPE = 6'h00;
    localparam logic [OPC_W-1:0] OP_J     = 6'h02;
    localparam logic [OPC_W-1:0] OP_JAL   = 6'h03;
    localparam logic [OPC_W-1:0] OP_BEQ   = 6'h04;
    localparam logic [OPC_W-1:0] OP_BNE   = 6'h05;
    localparam logic [OPC_W-1:0] OP_ADDIU = 6'h09;
    localparam logic [OPC_W-1:0] OP_SLTIU = 6'h0b;
    localparam logic [OPC_W-1:0] OP_ANDI  = 6'h0c;
    localparam logic [OPC_W-1:0] OP_ORI   = 6'h0d;
    localparam logic [OPC_W-1:0] OP_LUI   = 6'h0f;
    localparam logic [OPC_W-1:0] OP_LB    = 6'h20;
    localparam logic [OPC_W-1:0] OP_LW    = 6'h23;
    localparam logic [OPC_W-1:0] OP_SB    = 6'h28;
    localparam logic [OPC_W-1:0] OP_SW    = 6'h2b;

    // R-type function codes.
    localparam logic [FUNCT_W-1:0] FN_SLL  = 6'h00;
    localparam logic [FUNCT_W-1:0] FN_SRL  = 6'h02;
    localparam logic [FUNCT_W-1:0] FN_JR   = 6'h08;
    localparam logic [FUNCT_W-1:0] FN_ADDU = 6'h21;
    localparam logic [FUNCT_W-1:0] FN_AND  = 6'h24;
    localparam logic [FUNCT_W-1:0] FN_OR   = 6'h25;
    localparam logic [FUNCT_W-1:0] FN_NOR  = 6'h27;
    localparam logic [FUNCT_W-1:0] FN_SLTU = 6'h2b;

    typedef enum logic [1:0] {
        BR_NONE = 2'd0,
        BR_JUMP = 2'd1,
        BR_COND = 2'd2
    } t_branch;

    typedef enum logic [1:0] {
        EXT_ZERO = 2'd0,
        EXT_SIGN = 2'd1,
        EXT_NONE = 2'd2
    } t_ext;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_AND = 3'd2,
        ALU_OR  = 3'd3,
        ALU_NOR = 3'd4,
        ALU_SLT = 3'd5,
        ALU_SHL = 3'd6,
        ALU_SHR = 3'd7
    } t_alu_op;

    // One decoded control word.
    typedef struct packed {
        t_branch branch_kind;
        t_ext    extend_mode;
        logic    reg_write;
        logic    link_to_r31;
        logic    alu_src_imm;
        logic    alu_src_shamt;
        logic    dest_is_rt;
        t_alu_op alu_op;
        logic    mem_read;
        logic    mem_write;
        logic    mem_byte;
        logic    write_from_memory;
    } t_ctrl;

endpackage

FILE: rtl/mmcd_if.sv
// Valid/ready channel interfaces for the decoder's instruction input and control output.
// Depends on mmcd_pkg for the field widths.
interface mmcd_in_if;
    logic                        valid;
    logic                        ready;
    logic [mmcd_pkg::OPC_W-1:0]   opcode;
    logic [mmcd_pkg::FUNCT_W-1:0] function_code;

    modport source (output valid, output opcode, output function_code, input ready);
    modport sink   (input valid, input opcode, input function_code, output ready);
endinterface

interface mmcd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] branch_kind;
    logic [1:0] extend_mode;
    logic       reg_write;
    logic       link_to_r31;
    logic       alu_src_imm;
    logic       alu_src_shamt;
    logic       dest_is_rt;
    logic [2:0] alu_op;
    logic       mem_read;
    logic       mem_write;
    logic       mem_byte;
    logic       write_from_memory;

    modport source (
        output valid, output branch_kind, output extend_mode, output reg_write,
        output link_to_r31, output alu_src_imm, output alu_src_shamt, output dest_is_rt,
        output alu_op, output mem_read, output mem_write, output mem_byte,
        output write_from_memory, input ready
    );
    modport sink (
        input valid, input branch_kind, input extend_mode, input reg_write,
        input link_to_r31, input alu_src_imm, input alu_src_shamt, input dest_is_rt,
        input alu_op, input mem_read, input mem_write, input mem_byte,
        input write_from_memory, output ready
    );
endinterface

FILE: rtl/mmcd_decode.sv
// Combinational opcode/function decode into one control word.
// Depends on mmcd_pkg for encodings and the control word type.
module mmcd_decode (
    input  logic [mmcd_pkg::OPC_W-1:0]   i_opcode,
    input  logic [mmcd_pkg::FUNCT_W-1:0] i_function_code,
    output mmcd_pkg::t_ctrl              o_ctrl
);
    import mmcd_pkg::*;

    t_ctrl c;

    always_comb begin
        c = '0;
        case (i_opcode)
            OP_J: begin
                c.branch_kind = BR_JUMP;
                c.extend_mode = EXT_NONE;
            end
            OP_JAL: begin
                c.branch_kind = BR_JUMP;
                c.extend_mode = EXT_NONE;
                c.reg_write   = 1'b1;
                c.link_to_r31 = 1'b1;
                c.alu_src_imm = 1'b1;
            end
            OP_BEQ, OP_BNE: begin
                c.branch_kind = BR_COND;
                c.alu_op      = ALU_SUB;
            end
            OP_RTYPE: begin
                if (i_function_code == FN_JR) begin
                    c.branch_kind = BR_JUMP;
                end else begin
                    c.reg_write   = 1'b1;
                    c.extend_mode = EXT_NONE;
                    case (i_function_code)
                        FN_ADDU: c.alu_op = ALU_ADD;
                        FN_AND:  c.alu_op = ALU_AND;
                        FN_NOR:  c.alu_op = ALU_NOR;
                        FN_OR:   c.alu_op = ALU_OR;
                        FN_SLTU: c.alu_op = ALU_SLT;
                        FN_SLL: begin
                            c.alu_op        = ALU_SHL;
                            c.alu_src_imm   = 1'b1;
                            c.alu_src_shamt = 1'b1;
                        end
                        FN_SRL: begin
                            c.alu_op        = ALU_SHR;
                            c.alu_src_imm   = 1'b1;
                            c.alu_src_shamt = 1'b1;
                        end
                        // Any other function code falls back to subtract.
                        default: c.alu_op = ALU_SUB;
                    endcase
                end
            end
            default: begin
                // Every remaining opcode is treated as I-type.
                c.alu_src_imm = 1'b1;
                c.dest_is_rt  = 1'b1;
                c.reg_write   = 1'b1;
                case (i_opcode)
                    OP_ADDIU: begin
                        c.alu_op      = ALU_ADD;
                        c.extend_mode = EXT_SIGN;
                    end
                    OP_ANDI:  c.alu_op = ALU_AND;
                    OP_LUI:   c.alu_op = ALU_SHL;
                    OP_ORI:   c.alu_op = ALU_OR;
                    OP_SLTIU: c.alu_op = ALU_SLT;
                    OP_LW: begin
                        c.mem_read          = 1'b1;
                        c.write_from_memory = 1'b1;
                    end
                    OP_LB: begin
                        c.mem_read          = 1'b1;
                        c.mem_byte          = 1'b1;
                        c.write_from_memory = 1'b1;
                    end
                    OP_SW: begin
                        c.mem_write = 1'b1;
                        c.reg_write = 1'b0;
                    end
                    OP_SB: begin
                        c.mem_write = 1'b1;
                        c.mem_byte  = 1'b1;
                        c.reg_write = 1'b0;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    assign o_ctrl = c;

endmodule

FILE: rtl/mips_main_control_decoder.sv
// MIPS main control decoder: instruction register, decode logic, control word register.
// An accepted item is registered in stage one, decoded, and registered in stage two, where it is offered on o_out.
// Throughput is one item per cycle while o_out.ready is high; each stage advances whenever its successor is free.
// Reset (synchronous, active low) empties both stages; the payload registers are not cleared.
// Depends on mmcd_pkg, mmcd_if.sv, mmcd_decode and mips_main_control_decoder_assert.svh.
module mips_main_control_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mmcd_in_if.sink        i_in,
    mmcd_out_if.source     o_out
);
    import mmcd_pkg::*;

`include "mips_main_control_decoder_assert.svh"

    // Stage one holds the raw instruction fields of one item.
    logic                 r_s1_valid;
    logic [OPC_W-1:0]     r_s1_opcode;
    logic [FUNCT_W-1:0]   r_s1_funct;

    // Stage two holds the decoded control word that is offered downstream.
    logic                 r_s2_valid;
    t_ctrl                r_s2_ctrl;

    t_ctrl                n_s2_ctrl;
    logic                 s1_ready;
    logic                 s2_ready;
    logic                 in_fire;

    // A stage can take a new item when it is empty or when its own item leaves
    // in the same cycle. The chain lets a full pipeline keep moving each cycle while o_out.ready is high.
    assign s2_ready   = !r_s2_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_in.ready = s1_ready;
    assign in_fire    = i_in.valid && s1_ready;

    mmcd_decode u_decode (
        .i_opcode        (r_s1_opcode),
        .i_function_code (r_s1_funct),
        .o_ctrl          (n_s2_ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers load only when their stage advances, so a stalled
    // result holds its value.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_opcode <= i_in.opcode;
            r_s1_funct  <= i_in.function_code;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_ctrl <= n_s2_ctrl;
        end
    end

    assign o_out.valid             = r_s2_valid;
    assign o_out.branch_kind       = r_s2_ctrl.branch_kind;
    assign o_out.extend_mode       = r_s2_ctrl.extend_mode;
    assign o_out.reg_write         = r_s2_ctrl.reg_write;
    assign o_out.link_to_r31       = r_s2_ctrl.link_to_r31;
    assign o_out.alu_src_imm       = r_s2_ctrl.alu_src_imm;
    assign o_out.alu_src_shamt     = r_s2_ctrl.alu_src_shamt;
    assign o_out.dest_is_rt        = r_s2_ctrl.dest_is_rt;
    assign o_out.alu_op            = r_s2_ctrl.alu_op;
    assign o_out.mem_read          = r_s2_ctrl.mem_read;
    assign o_out.mem_write         = r_s2_ctrl.mem_write;
    assign o_out.mem_byte          = r_s2_ctrl.mem_byte;
    assign o_out.write_from_memory = r_s2_ctrl.write_from_memory;

    // An accepted item is always held in stage one on the next cycle.
    `MMCD_ASSERT(a_in_lands_s1, i_clk, i_rst_n, in_fire |=> r_s1_valid, "accepted item lost")
    // An item in stage one moves to stage two whenever stage two can take it.
    `MMCD_ASSERT(a_s1_to_s2, i_clk, i_rst_n, (r_s1_valid && s2_ready) |=> r_s2_valid, "stage one item dropped")
    // A store never also writes a register, and a link always writes r31.
    `MMCD_ASSERT(a_ctrl_consistent, i_clk, i_rst_n, r_s2_valid |-> (!(r_s2_ctrl.mem_write && r_s2_ctrl.reg_write) && (!r_s2_ctrl.link_to_r31 || (r_s2_ctrl.reg_write && r_s2_ctrl.branch_kind == BR_JUMP))), "inconsistent control word")
    // The unused branch code never appears on a valid result.
    `MMCD_ASSERT(a_branch_code, i_clk, i_rst_n, r_s2_valid |-> (r_s2_ctrl.branch_kind != 2'd3), "illegal branch kind")
    // Both stages are empty in the cycle after reset.
    `MMCD_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) |-> (!r_s1_valid && !r_s2_valid), "pipeline not empty after reset")

endmodule

FILE: test/mmcd_decode_checker.sv
// Watches both channels of the decoder, predicts each control word and compares it.
// Depends on mmcd_pkg and the channel interfaces in mmcd_if.sv.
module mmcd_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mmcd_in_if.sink     i_in_mon,
    mmcd_out_if.sink    i_out_mon,
    output int          o_fail_count,
    output int          o_pending
);
    import mmcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [OPC_W-1:0]   opcode;
        logic [FUNCT_W-1:0] funct;
        t_ctrl              ctrl;
    } t_decoded;

    t_decoded pending_ctrl[$];

    // Control word for one instruction; anything not named stays zero.
    function automatic t_ctrl decode_control(logic [OPC_W-1:0] op, logic [FUNCT_W-1:0] fn);
        t_ctrl c;
        c = '0;
        if (op == OP_J || op == OP_JAL) begin
            c.branch_kind = BR_JUMP;
            c.extend_mode = EXT_NONE;
            if (op == OP_JAL) begin
                c.reg_write   = 1'b1;
                c.link_to_r31 = 1'b1;
                c.alu_src_imm = 1'b1;
            end
        end else if (op == OP_BEQ || op == OP_BNE) begin
            c.branch_kind = BR_COND;
            c.alu_op      = ALU_SUB;
        end else if (op == OP_RTYPE && fn == FN_JR) begin
            c.branch_kind = BR_JUMP;
        end else if (op == OP_RTYPE) begin
            c.reg_write   = 1'b1;
            c.extend_mode = EXT_NONE;
            case (fn)
                FN_ADDU: c.alu_op = ALU_ADD;
                FN_AND:  c.alu_op = ALU_AND;
                FN_NOR:  c.alu_op = ALU_NOR;
                FN_OR:   c.alu_op = ALU_OR;
                FN_SLTU: c.alu_op = ALU_SLT;
                FN_SLL: begin
                    c.alu_op        = ALU_SHL;
                    c.alu_src_imm   = 1'b1;
                    c.alu_src_shamt = 1'b1;
                end
                FN_SRL: begin
                    c.alu_op        = ALU_SHR;
                    c.alu_src_imm   = 1'b1;
                    c.alu_src_shamt = 1'b1;
                end
                default: c.alu_op = ALU_SUB;
            endcase
        end else begin
            c.alu_src_imm = 1'b1;
            c.dest_is_rt  = 1'b1;
            c.reg_write   = 1'b1;
            case (op)
                OP_ADDIU: begin
                    c.alu_op      = ALU_ADD;
                    c.extend_mode = EXT_SIGN;
                end
                OP_ANDI:  c.alu_op = ALU_AND;
                OP_LUI:   c.alu_op = ALU_SHL;
                OP_ORI:   c.alu_op = ALU_OR;
                OP_SLTIU: c.alu_op = ALU_SLT;
                OP_LW: begin
                    c.alu_op            = ALU_ADD;
                    c.mem_read          = 1'b1;
                    c.write_from_memory = 1'b1;
                end
                OP_LB: begin
                    c.alu_op            = ALU_ADD;
                    c.mem_read          = 1'b1;
                    c.mem_byte          = 1'b1;
                    c.write_from_memory = 1'b1;
                end
                OP_SW: begin
                    c.alu_op    = ALU_ADD;
                    c.mem_write = 1'b1;
                    c.reg_write = 1'b0;
                end
                OP_SB: begin
                    c.alu_op    = ALU_ADD;
                    c.mem_write = 1'b1;
                    c.mem_byte  = 1'b1;
                    c.reg_write = 1'b0;
                end
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, t_decoded d, logic [2:0] got, logic [2:0] want);
        $display("%0t: %s mismatch for opcode %h funct %h: got %0d, expected %0d",
                 $realtime, what, d.opcode, d.funct, got, want);
        o_fail_count++;
    endtask

    task automatic check_field(string what, t_decoded d, logic [2:0] got, logic [2:0] want);
        if (got !== want)
            report_mismatch(what, d, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_decoded d;
        if (i_rst_n) begin
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (pending_ctrl.size() == 0) begin
                    d.opcode = 'x;
                    d.funct  = 'x;
                    d.ctrl   = '0;
                    report_mismatch("unexpected item", d, i_out_mon.alu_op, 'x);
                end else begin
                    d = pending_ctrl.pop_front();
                    check_field("branch_kind", d, 3'(i_out_mon.branch_kind),
                                3'(d.ctrl.branch_kind));
                    check_field("extend_mode", d, 3'(i_out_mon.extend_mode),
                                3'(d.ctrl.extend_mode));
                    check_field("reg_write", d, 3'(i_out_mon.reg_write),
                                3'(d.ctrl.reg_write));
                    check_field("link_to_r31", d, 3'(i_out_mon.link_to_r31),
                                3'(d.ctrl.link_to_r31));
                    check_field("alu_src_imm", d, 3'(i_out_mon.alu_src_imm),
                                3'(d.ctrl.alu_src_imm));
                    check_field("alu_src_shamt", d, 3'(i_out_mon.alu_src_shamt),
                                3'(d.ctrl.alu_src_shamt));
                    check_field("dest_is_rt", d, 3'(i_out_mon.dest_is_rt),
                                3'(d.ctrl.dest_is_rt));
                    check_field("alu_op", d, i_out_mon.alu_op, d.ctrl.alu_op);
                    check_field("mem_read", d, 3'(i_out_mon.mem_read),
                                3'(d.ctrl.mem_read));
                    check_field("mem_write", d, 3'(i_out_mon.mem_write),
                                3'(d.ctrl.mem_write));
                    check_field("mem_byte", d, 3'(i_out_mon.mem_byte),
                                3'(d.ctrl.mem_byte));
                    check_field("write_from_memory", d, 3'(i_out_mon.write_from_memory),
                                3'(d.ctrl.write_from_memory));
                end
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                d.opcode = i_in_mon.opcode;
                d.funct  = i_in_mon.function_code;
                d.ctrl   = decode_control(i_in_mon.opcode, i_in_mon.function_code);
                pending_ctrl.push_back(d);
            end
        end
        o_pending <= pending_ctrl.size();
    end

endmodule

FILE: test/tb_top.sv
// Top of the decoder testbench: clock, reset, instruction stimulus and the verdict.
// Depends on mmcd_pkg, mmcd_if.sv, the decoder RTL and mmcd_decode_checker.
module tb_top;
    import mmcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The decoder pipeline is short, so a short settle at the end is plenty.
    localparam int RANDOM_ITEMS = 950;
    localparam int SETTLE_CYCLES = 8;
    // This limit is far beyond the length of the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;

    mmcd_in_if  in_ch ();
    mmcd_out_if out_ch ();

    int fail_count;
    int pending_count;
    int cycle_count;

    // While set, neither the instruction sender nor the result receiver holds back.
    bit steady_run;

    // Every opcode that is not R-type but has a decode of its own.
    logic [OPC_W-1:0] known_ops [0:12] = '{
        OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTIU, OP_ANDI,
        OP_ORI, OP_LUI, OP_LB, OP_LW, OP_SB, OP_SW
    };

    // Every R-type function code with a decode of its own, jr among them.
    logic [FUNCT_W-1:0] known_fns [0:7] = '{
        FN_SLL, FN_SRL, FN_JR, FN_ADDU, FN_AND, FN_OR, FN_NOR, FN_SLTU
    };

    mips_main_control_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mmcd_decode_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: ready drops in roughly a quarter of the cycles, except during
    // the steady stretch, so that stalls land on every stage of the pipeline.
    always @(posedge i_clk) begin
        if (steady_run)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(99) >= 24);
    end

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one instruction and returns at the edge where it is accepted. A random
    // gap may come first; valid is only lowered there, so within any one time step
    // it receives a single assignment. After acceptance valid stays high, so a
    // back-to-back item simply overwrites the payload at the same edge.
    task automatic issue_instruction(input logic [OPC_W-1:0] op, input logic [FUNCT_W-1:0] fn);
        if (!steady_run && $urandom_range(99) < 24) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= op;
        in_ch.function_code <= fn;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    // Holds the sender off until every decoded word has come out. The first edge
    // is always waited so that the last acceptance is already counted as pending.
    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    initial begin : stimulus
        logic [OPC_W-1:0]   op;
        logic [FUNCT_W-1:0] fn;
        int                 pick;

        steady_run          = 1'b0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= '0;
        in_ch.function_code <= '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Every R-type function with a decode, jr among them, and an unlisted
        // function near each end of the range.
        foreach (known_fns[k]) issue_instruction(OP_RTYPE, known_fns[k]);
        issue_instruction(OP_RTYPE, 6'h3f);
        issue_instruction(OP_RTYPE, 6'h01);
        // Every other listed opcode with an all-ones function field, which must be
        // ignored, then unlisted I-type opcodes at both ends of the range.
        foreach (known_ops[k]) issue_instruction(known_ops[k], 6'h3f);
        issue_instruction(6'h3f, 6'h00);
        issue_instruction(6'h01, 6'h08);

        // Let the pipeline run dry once before the random part.
        drain_pipeline();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // A long stretch in the middle runs at full rate on both sides.
            steady_run = (n >= 400 && n < 600);

            // Most items are real instructions; the rest cover the whole field
            // space, including opcodes nothing decodes.
            pick = $urandom_range(99);
            fn   = FUNCT_W'($urandom_range(63));
            if (pick < 35) begin
                op = known_ops[4'($urandom_range(12))];
            end else if (pick < 65) begin
                op = OP_RTYPE;
                fn = known_fns[3'($urandom_range(7))];
            end else if (pick < 75) begin
                op = OP_RTYPE;
            end else begin
                op = OPC_W'($urandom_range(63));
            end
            issue_instruction(op, fn);

            if (n == 700)
                drain_pipeline();
        end
        steady_run = 1'b0;

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: mips_main_control_decoder.f
+incdir+rtl
rtl/mmcd_pkg.sv
rtl/mmcd_if.sv
rtl/mmcd_decode.sv
rtl/mips_main_control_decoder.sv
test/mmcd_decode_checker.sv
test/tb_top.sv
